[hdl/assert_macros.svh]
// Assertion helper macros for the permutation move-and-rank engine.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/pmr_pkg.sv]
// Shared types, tables and helper functions for the permutation engine.
// No dependencies; imported by every module of the block.
package pmr_pkg;

    localparam int NPOS = 12;
    localparam logic [28:0] RANK_LIMIT = 29'd479001600;
    localparam logic [3:0] LAST_DIGIT = 4'(NPOS - 1);

    typedef struct packed {
        logic        op;
        logic [28:0] rank_in;
        logic [3:0]  move;
    } req_t;

    typedef struct packed {
        logic [28:0] rank_out;
        logic        error;
    } rsp_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_HOLD,
        ST_SHIFT,
        ST_ROTATE,
        ST_MOVE
    } store_op_t;

    typedef struct packed {
        store_op_t  op;
        logic [3:0] move;
        logic [3:0] piece;
    } store_ctrl_t;

    typedef enum logic [1:0] {
        AR_RECIP,
        AR_FIX,
        AR_RANK
    } arith_op_t;

    typedef struct packed {
        logic [3:0]  q_est;
        logic [3:0]  q;
        logic [28:0] r;
        logic [28:0] sum;
    } arith_res_t;

    // Three positions per move: c0 takes c1, c1 takes c2, c2 takes c0.
    localparam logic [3:0] CYCLE_TAB [16][3] = '{
        '{4'd2, 4'd1, 4'd0},  '{4'd3, 4'd4, 4'd0},  '{4'd6, 4'd5, 4'd1},
        '{4'd5, 4'd7, 4'd3},  '{4'd8, 4'd9, 4'd2},  '{4'd10, 4'd8, 4'd4},
        '{4'd9, 4'd11, 4'd6}, '{4'd11, 4'd10, 4'd7},
        '{4'd0, 4'd1, 4'd2},  '{4'd0, 4'd4, 4'd3},  '{4'd1, 4'd5, 4'd6},
        '{4'd3, 4'd7, 4'd5},  '{4'd2, 4'd9, 4'd8},  '{4'd4, 4'd8, 4'd10},
        '{4'd6, 4'd11, 4'd9}, '{4'd7, 4'd10, 4'd11}
    };

    // Factorial weight of digit position d.
    function automatic logic [28:0] weight_of(input logic [3:0] d);
        logic [28:0] w;
        case (d)
            4'd0:    w = 29'd39916800;
            4'd1:    w = 29'd3628800;
            4'd2:    w = 29'd362880;
            4'd3:    w = 29'd40320;
            4'd4:    w = 29'd5040;
            4'd5:    w = 29'd720;
            4'd6:    w = 29'd120;
            4'd7:    w = 29'd24;
            4'd8:    w = 29'd6;
            4'd9:    w = 29'd2;
            4'd10:   w = 29'd1;
            4'd11:   w = 29'd1;
            default: w = 29'd0;
        endcase
        return w;
    endfunction

    // floor(2^32 / weight), clipped to 32 bits for a weight of one.
    function automatic logic [31:0] recip_of(input logic [3:0] d);
        logic [31:0] m;
        case (d)
            4'd0:    m = 32'd107;
            4'd1:    m = 32'd1183;
            4'd2:    m = 32'd11835;
            4'd3:    m = 32'd106522;
            4'd4:    m = 32'd852176;
            4'd5:    m = 32'd5965232;
            4'd6:    m = 32'd35791394;
            4'd7:    m = 32'd178956970;
            4'd8:    m = 32'd715827882;
            4'd9:    m = 32'd2147483648;
            4'd10:   m = 32'd4294967295;
            4'd11:   m = 32'd4294967295;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

    // Source position that position p takes its piece from under move mv.
    function automatic logic [3:0] move_src(input logic [3:0] mv, input logic [3:0] p);
        logic [3:0] src;
        src = p;
        if (p == CYCLE_TAB[mv][0]) src = CYCLE_TAB[mv][1];
        else if (p == CYCLE_TAB[mv][1]) src = CYCLE_TAB[mv][2];
        else if (p == CYCLE_TAB[mv][2]) src = CYCLE_TAB[mv][0];
        return src;
    endfunction

endpackage

[hdl/permutation_move_and_rank_engine.sv]
// Permutation move-and-rank engine: keeps a permutation of twelve pieces
// (identity after reset), loads it from a Lehmer rank or applies one of
// sixteen fixed three-way rotations, and returns the rank after every beat. One
// request is handled at a time; a move, or a load whose rank is out of range,
// skips unranking and goes straight to ranking. Unranking and ranking share
// the single multiplier: unranking takes each digit as a reciprocal estimate,
// then a remainder correction, and a further step places the last piece;
// ranking takes the positions in turn as the piece store rotates past its
// head. The result register lets the next request be accepted while a result
// still waits to be taken.
// Depends on pmr_pkg, pmr_arith, pmr_store and assert_macros.svh.
`include "assert_macros.svh"

module permutation_move_and_rank_engine
    import pmr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_MUL,
        S_DIV_FIX,
        S_PICK_LAST,
        S_RANK,
        S_FINISH
    } state_t;

    state_t      state_reg;
    logic [3:0]  digit_reg;
    logic [28:0] r_reg;
    logic [3:0]  q_est_reg;
    logic [3:0]  q_reg;
    logic        pick_pending_reg;
    logic [11:0] unused_reg;
    logic [11:0] seen_reg;
    logic [28:0] sum_reg;
    logic        err_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;

    store_ctrl_t store_ctrl;
    logic [3:0]  head;
    arith_op_t   arith_op;
    arith_res_t  arith_res;
    logic [3:0]  piece;
    logic [11:0] unused_next;
    logic [3:0]  rank_cnt;
    logic [11:0] seen_next;
    logic        accept;
    logic        rank_start;

    function automatic logic [3:0] popcount12(input logic [11:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < NPOS; k++)
        begin
            n = n + {3'b000, v[k]};
        end
        return n;
    endfunction

    function automatic logic [11:0] low_mask(input logic [3:0] n);
        logic [11:0] m;
        for (int k = 0; k < NPOS; k++)
        begin
            m[k] = (4'(k) < n);
        end
        return m;
    endfunction

    function automatic logic [11:0] one_hot(input logic [3:0] n);
        logic [11:0] m;
        for (int k = 0; k < NPOS; k++)
        begin
            m[k] = (4'(k) == n);
        end
        return m;
    endfunction

    // Pick the q-th still unused piece.
    function automatic logic [3:0] pick_piece(input logic [11:0] unused,
                                              input logic [3:0] q);
        logic [3:0] idx;
        idx = 4'd0;
        for (int j = 0; j < NPOS; j++)
        begin
            if (unused[j] && (popcount12(unused & low_mask(4'(j))) == q))
            begin
                idx = 4'(j);
            end
        end
        return idx;
    endfunction

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign piece       = pick_piece(unused_reg, q_reg);
    assign unused_next = unused_reg & ~one_hot(piece);
    assign rank_cnt    = popcount12(~seen_reg & low_mask(head));
    assign seen_next   = seen_reg | one_hot(head);
    assign rank_start  = (state_reg == S_RANK) && (digit_reg == 4'd0);

    always_comb
    begin
        store_ctrl.op    = ST_HOLD;
        store_ctrl.move  = req.move;
        store_ctrl.piece = piece;
        arith_op         = AR_RANK;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.op == OP_MOVE)) store_ctrl.op = ST_MOVE;
            end
            S_DIV_MUL:
            begin
                arith_op = AR_RECIP;
                if (pick_pending_reg) store_ctrl.op = ST_SHIFT;
            end
            S_DIV_FIX:   arith_op = AR_FIX;
            S_PICK_LAST: store_ctrl.op = ST_SHIFT;
            S_RANK:      store_ctrl.op = ST_ROTATE;
            default:
            begin
            end
        endcase
    end

    pmr_arith u_arith (
        .op    (arith_op),
        .digit (digit_reg),
        .r     (r_reg),
        .q_est (q_est_reg),
        .cnt   (rank_cnt),
        .sum   (sum_reg),
        .res   (arith_res)
    );

    pmr_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (store_ctrl),
        .head  (head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            digit_reg        <= 4'd0;
            pick_pending_reg <= 1'b0;
            unused_reg       <= '1;
            seen_reg         <= '0;
            sum_reg          <= '0;
            err_reg          <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            r_reg            <= '0;
            q_est_reg        <= '0;
            q_reg            <= '0;
            rsp_reg          <= '0;
        end
        else
        begin
            // Load a finished result, or drop the one just taken.
            if ((state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        digit_reg <= 4'd0;
                        seen_reg  <= '0;
                        sum_reg   <= '0;
                        if (req.op == OP_MOVE)
                        begin
                            err_reg   <= 1'b0;
                            state_reg <= S_RANK;
                        end
                        else if (req.rank_in >= RANK_LIMIT)
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= S_RANK;
                        end
                        else
                        begin
                            err_reg          <= 1'b0;
                            r_reg            <= req.rank_in;
                            unused_reg       <= '1;
                            pick_pending_reg <= 1'b0;
                            state_reg        <= S_DIV_MUL;
                        end
                    end
                end
                S_DIV_MUL:
                begin
                    q_est_reg <= arith_res.q_est;
                    if (pick_pending_reg) unused_reg <= unused_next;
                    state_reg <= S_DIV_FIX;
                end
                S_DIV_FIX:
                begin
                    q_reg            <= arith_res.q;
                    r_reg            <= arith_res.r;
                    pick_pending_reg <= 1'b1;
                    if (digit_reg == LAST_DIGIT)
                    begin
                        state_reg <= S_PICK_LAST;
                    end
                    else
                    begin
                        digit_reg <= digit_reg + 4'd1;
                        state_reg <= S_DIV_MUL;
                    end
                end
                S_PICK_LAST:
                begin
                    unused_reg <= unused_next;
                    digit_reg  <= 4'd0;
                    seen_reg   <= '0;
                    sum_reg    <= '0;
                    state_reg  <= S_RANK;
                end
                S_RANK:
                begin
                    sum_reg  <= arith_res.sum;
                    seen_reg <= seen_next;
                    if (digit_reg == LAST_DIGIT)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        digit_reg <= digit_reg + 4'd1;
                    end
                end
                S_FINISH:
                begin
                    // Hold until the result register is free.
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg.rank_out <= sum_reg;
                        rsp_reg.error    <= err_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !req_ready)
    `ASSERT_IMPLIES(a_rank_in_range, clk, rst_n, rsp_valid, rsp.rank_out < RANK_LIMIT)
    `ASSERT_IMPLIES(a_rank_walk_fresh, clk, rst_n, rank_start, (seen_reg == '0) && (sum_reg == '0))
    `ASSERT_IMPLIES(a_unrank_pieces_left, clk, rst_n, state_reg == S_PICK_LAST, $countones(unused_reg) == 1)

endmodule

[hdl/pmr_arith.sv]
// Shared multiply/subtract/accumulate unit of the permutation engine.
// Depends on pmr_pkg for the weight and reciprocal tables.
module pmr_arith
    import pmr_pkg::*;
(
    input  arith_op_t   op,
    input  logic [3:0]  digit,
    input  logic [28:0] r,
    input  logic [3:0]  q_est,
    input  logic [3:0]  cnt,
    input  logic [28:0] sum,
    output arith_res_t  res
);

    logic [28:0] w;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [28:0] rem;
    logic        ge;

    assign w = weight_of(digit);

    // One multiplier serves quotient estimate, remainder and rank term.
    always_comb
    begin
        case (op)
            AR_RECIP:
            begin
                mul_a = {3'b000, r};
                mul_b = recip_of(digit);
            end
            AR_FIX:
            begin
                mul_a = {28'd0, q_est};
                mul_b = {3'b000, w};
            end
            AR_RANK:
            begin
                mul_a = {28'd0, cnt};
                mul_b = {3'b000, w};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Estimate is never above the true quotient and at most one below it.
    assign rem = r - prod[28:0];
    assign ge  = (rem >= w);

    assign res.q_est = prod[35:32];
    assign res.q     = q_est + {3'b000, ge};
    assign res.r     = ge ? (rem - w) : rem;
    assign res.sum   = sum + prod[28:0];

endmodule

[hdl/pmr_store.sv]
// Twelve-entry piece store: shift-in, rotate and three-way position swap.
// Depends on pmr_pkg for the control struct and move table.
module pmr_store
    import pmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  store_ctrl_t ctrl,
    output logic [3:0]  head
);

    logic [3:0] pos_reg  [NPOS];
    logic [3:0] pos_next [NPOS];

    always_comb
    begin
        for (int p = 0; p < NPOS; p++)
        begin
            pos_next[p] = pos_reg[p];
        end
        case (ctrl.op)
            ST_SHIFT:
            begin
                for (int p = 0; p < NPOS - 1; p++)
                begin
                    pos_next[p] = pos_reg[p + 1];
                end
                pos_next[NPOS - 1] = ctrl.piece;
            end
            ST_ROTATE:
            begin
                for (int p = 0; p < NPOS - 1; p++)
                begin
                    pos_next[p] = pos_reg[p + 1];
                end
                pos_next[NPOS - 1] = pos_reg[0];
            end
            ST_MOVE:
            begin
                for (int p = 0; p < NPOS; p++)
                begin
                    pos_next[p] = pos_reg[move_src(ctrl.move, 4'(p))];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NPOS; p++)
            begin
                pos_reg[p] <= 4'(p);
            end
        end
        else
        begin
            for (int p = 0; p < NPOS; p++)
            begin
                pos_reg[p] <= pos_next[p];
            end
        end
    end

    assign head = pos_reg[0];

endmodule

[tb/permutation_move_and_rank_engine_tb.sv]
// Testbench for the permutation move-and-rank engine: directed loads and moves, then
// random beats with random idling on both channels, each result checked against the
// table value or a local model of twelve pieces. Depends on pmr_pkg and engine RTL.
`timescale 1ns / 100ps

module permutation_move_and_rank_engine_tb;
    import pmr_pkg::*;

    localparam int unsigned RANDOM_BEATS   = 900;
    localparam int unsigned MAX_GAP        = 16;
    localparam int unsigned HOLD_AT_RESULT = 300;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned DRAIN_CYCLES   = 60;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RANK_TOP       = 479001599;
    localparam int unsigned FIELD_TOP      = 536870911;

    localparam int unsigned FACT_WEIGHT [12] = '{
        39916800, 3628800, 362880, 40320, 5040, 720, 120, 24, 6, 2, 1, 1
    };

    // Positions c0, c1, c2 of each three-cycle: c0 takes c1, c1 takes c2, c2 takes c0.
    localparam logic [3:0] THREE_CYCLE [16][3] = '{
        '{4'd2, 4'd1, 4'd0},  '{4'd3, 4'd4, 4'd0},  '{4'd6, 4'd5, 4'd1},
        '{4'd5, 4'd7, 4'd3},  '{4'd8, 4'd9, 4'd2},  '{4'd10, 4'd8, 4'd4},
        '{4'd9, 4'd11, 4'd6}, '{4'd11, 4'd10, 4'd7},
        '{4'd0, 4'd1, 4'd2},  '{4'd0, 4'd4, 4'd3},  '{4'd1, 4'd5, 4'd6},
        '{4'd3, 4'd7, 4'd5},  '{4'd2, 4'd9, 4'd8},  '{4'd4, 4'd8, 4'd10},
        '{4'd6, 4'd11, 4'd9}, '{4'd7, 4'd10, 4'd11}
    };

    typedef struct {
        req_t beat;
        bit   typed;
        rsp_t want;
    } stim_row_t;

    localparam int unsigned DIRECTED_ROWS = 25;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    logic [3:0]  piece_at [12];
    rsp_t        pending_ranks [$];
    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{OP_LOAD, 29'd0, 4'd15},         1'b1, '{29'd0, 1'b0}},
        '{'{OP_LOAD, 29'd479001599, 4'd0},  1'b1, '{29'd479001599, 1'b0}},
        '{'{OP_LOAD, 29'd479001600, 4'd7},  1'b1, '{29'd479001599, 1'b1}},
        '{'{OP_LOAD, 29'h1FFFFFFF, 4'd8},   1'b1, '{29'd479001599, 1'b1}},
        '{'{OP_LOAD, 29'd0, 4'd0},          1'b1, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'h1FFFFFFF, 4'd0},   1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'd0, 4'd1},          1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'h1FFFFFFF, 4'd2},   1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'd0, 4'd3},          1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'h1FFFFFFF, 4'd4},   1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'd0, 4'd5},          1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'h1FFFFFFF, 4'd6},   1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'd0, 4'd7},          1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'h1FFFFFFF, 4'd8},   1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'd0, 4'd9},          1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'h1FFFFFFF, 4'd10},  1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'd0, 4'd11},         1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'h1FFFFFFF, 4'd12},  1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'd0, 4'd13},         1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'h1FFFFFFF, 4'd14},  1'b0, '{29'd0, 1'b0}},
        '{'{OP_MOVE, 29'd0, 4'd15},         1'b0, '{29'd0, 1'b0}},
        '{'{OP_LOAD, 29'd1, 4'd15},         1'b1, '{29'd1, 1'b0}},
        '{'{OP_LOAD, 29'd39916800, 4'd9},   1'b1, '{29'd39916800, 1'b0}},
        '{'{OP_MOVE, 29'd12345, 4'd8},      1'b0, '{29'd0, 1'b0}},
        '{'{OP_LOAD, 29'd268435456, 4'd3},  1'b1, '{29'd268435456, 1'b0}}
    };

    permutation_move_and_rank_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [28:0] rank_of_pieces();
        bit          seen [16];
        int unsigned total;
        int unsigned below;
        int unsigned a;
        total = 0;
        for (int k = 0; k < 16; k++) seen[k] = 1'b0;
        for (int i = 0; i < 12; i++)
        begin
            a = piece_at[i];
            below = 0;
            for (int j = 0; j < a; j++)
                if (!seen[j]) below++;
            seen[a] = 1'b1;
            total += below * FACT_WEIGHT[i];
        end
        return total[28:0];
    endfunction

    // Digit i picks the q-th piece still free.
    function automatic void unrank_pieces(input logic [28:0] code);
        bit          taken [12];
        int unsigned rest;
        int unsigned q;
        int unsigned free_seen;
        rest = code;
        for (int k = 0; k < 12; k++) taken[k] = 1'b0;
        for (int i = 0; i < 12; i++)
        begin
            q = rest / FACT_WEIGHT[i];
            free_seen = 0;
            for (int j = 0; j < 12; j++)
            begin
                if (!taken[j])
                begin
                    if (free_seen == q)
                    begin
                        piece_at[i] = 4'(j);
                        taken[j] = 1'b1;
                        break;
                    end
                    free_seen++;
                end
            end
            rest = rest % FACT_WEIGHT[i];
        end
    endfunction

    function automatic void turn_cycle(input logic [3:0] mv);
        logic [3:0] held;
        held = piece_at[THREE_CYCLE[mv][0]];
        piece_at[THREE_CYCLE[mv][0]] = piece_at[THREE_CYCLE[mv][1]];
        piece_at[THREE_CYCLE[mv][1]] = piece_at[THREE_CYCLE[mv][2]];
        piece_at[THREE_CYCLE[mv][2]] = held;
    endfunction

    function automatic rsp_t step_permutation(input req_t beat);
        rsp_t res;
        res.error = 1'b0;
        if (beat.op == OP_LOAD)
        begin
            if (beat.rank_in >= RANK_LIMIT) res.error = 1'b1;
            else unrank_pieces(beat.rank_in);
        end
        else
        begin
            turn_cycle(beat.move);
        end
        res.rank_out = rank_of_pieces();
        return res;
    endfunction

    // Quiet windows give stretches with no idling at all.
    function automatic int unsigned draw_gap(input int unsigned count);
        if ((count % 160) >= 120) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic req_t random_beat();
        req_t        b;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        b.op = (roll < 60) ? OP_MOVE : OP_LOAD;
        b.rank_in = 29'($urandom);
        b.move = 4'($urandom);
        if (roll >= 60 && roll < 88)
            b.rank_in = 29'($urandom_range(0, RANK_TOP));
        else if (roll >= 88 && roll < 94)
        begin
            case ($urandom_range(0, 3))
                0: b.rank_in = 29'd0;
                1: b.rank_in = 29'(RANK_TOP);
                2: b.rank_in = RANK_LIMIT;
                default: b.rank_in = 29'h1FFFFFFF;
            endcase
        end
        else if (roll >= 94)
            b.rank_in = 29'($urandom_range(RANK_TOP + 1, FIELD_TOP));
        return b;
    endfunction

    // Entered and left at a falling edge; valid stays high when there is no gap.
    task automatic send_beat(input req_t beat, input bit typed, input rsp_t want,
                             input int unsigned gap);
        rsp_t predicted;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= beat;
        do @(posedge clk); while (!req_ready);
        predicted = step_permutation(beat);
        pending_ranks.insert(pending_ranks.size(), typed ? want : predicted);
        @(negedge clk);
    endtask

    initial
    begin : req_side
        int unsigned sent;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        mismatch_count = 0;
        for (int i = 0; i < 12; i++) piece_at[i] = 4'(i);
        sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want,
                      draw_gap(sent));
            sent++;
        end
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            send_beat(random_beat(), 1'b0, '0, draw_gap(sent));
            sent++;
        end
        req_valid <= 1'b0;

        while (pending_ranks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : rsp_side
        int unsigned taken;
        int unsigned stall;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = draw_gap(taken);
            // Hold off once for long enough that the engine backs up its input.
            if (taken == HOLD_AT_RESULT) stall = HOLD_CYCLES;
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin : check_and_watch
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_ranks.size() == 0)
            begin
                $error("result beat with nothing pending: rank_out %0d error %0b",
                       rsp.rank_out, rsp.error);
                mismatch_count++;
            end
            else
            begin
                want = pending_ranks.pop_front();
                if (rsp.rank_out !== want.rank_out)
                begin
                    $error("rank_out: expected %0d, got %0d", want.rank_out, rsp.rank_out);
                    mismatch_count++;
                end
                if (rsp.error !== want.error)
                begin
                    $error("error: expected %0b, got %0b", want.error, rsp.error);
                    mismatch_count++;
                end
            end
        end
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule
